// ===== rtl/s256md_pkg.sv =====
// s256md_pkg: shared types, constants and SHA-256 helper functions.
// No dependencies; used by every module of the digest core.
package s256md_pkg;

  typedef logic [31:0] word_t;

  // Control from the sequencer to the message schedule
  typedef struct packed {
    logic       shift_byte;  // shift one byte into the block
    logic       shift_word;  // advance the schedule by one word
    logic [7:0] data;        // byte to shift in
  } sched_ctl_t;

  // Control from the sequencer to the compression unit
  typedef struct packed {
    logic load;     // working vars <= hash
    logic step;     // one compression round
    logic fold;     // hash += working vars
    logic restart;  // hash <= initial values
  } rnd_ctl_t;

  localparam word_t INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_MARKER = 8'h80;
  localparam logic [5:0] LEN_POS    = 6'd56;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t ssig0(input word_t x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t round_k(input logic [5:0] idx);
    case (idx)
      6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
      default: round_k = 32'h00000000;
    endcase
  endfunction

endpackage

// ===== rtl/s256md_sched.sv =====
// s256md_sched: 512-bit block register and message schedule.
// Depends on s256md_pkg. Bytes shift in big-endian; rounds shift words out.
module s256md_sched (
  input  logic                  clk,
  input  s256md_pkg::sched_ctl_t ctl,
  output s256md_pkg::word_t     w_cur
);

  logic [511:0]      blk_r;
  logic [511:0]      blk_nxt;
  s256md_pkg::word_t w_new;

  // Word k of the window sits at blk_r[511-32k -: 32]; word 0 is W[t]
  assign w_cur = blk_r[511:480];
  assign w_new = s256md_pkg::ssig1(blk_r[63:32]) + blk_r[223:192]
               + s256md_pkg::ssig0(blk_r[479:448]) + blk_r[511:480];

  always_comb begin
    blk_nxt = blk_r;
    if (ctl.shift_byte) begin
      blk_nxt = {blk_r[503:0], ctl.data};
    end else if (ctl.shift_word) begin
      blk_nxt = {blk_r[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

endmodule

// ===== rtl/s256md_round.sv =====
// s256md_round: hash state, working variables and the single round unit.
// Depends on s256md_pkg. One compression round per step.
module s256md_round (
  input  logic                  clk,
  input  logic                  rst_n,
  input  s256md_pkg::rnd_ctl_t  ctl,
  input  logic [5:0]            k_idx,
  input  s256md_pkg::word_t     w_t,
  output s256md_pkg::word_t     hash [8]
);

  s256md_pkg::word_t hash_r [8];
  s256md_pkg::word_t wv_r   [8];
  s256md_pkg::word_t t1;
  s256md_pkg::word_t t2;
  s256md_pkg::word_t ch;
  s256md_pkg::word_t mj;

  assign ch = (wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]);
  assign mj = (wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]);
  assign t1 = wv_r[7] + s256md_pkg::bsig1(wv_r[4]) + ch
            + s256md_pkg::round_k(k_idx) + w_t;
  assign t2 = s256md_pkg::bsig0(wv_r[0]) + mj;

  assign hash = hash_r;

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.restart) begin
      hash_r <= s256md_pkg::INIT_HASH;
    end else if (ctl.fold) begin
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= hash_r[i] + wv_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      wv_r <= hash_r;
    end else if (ctl.step) begin
      wv_r[7] <= wv_r[6];
      wv_r[6] <= wv_r[5];
      wv_r[5] <= wv_r[4];
      wv_r[4] <= wv_r[3] + t1;
      wv_r[3] <= wv_r[2];
      wv_r[2] <= wv_r[1];
      wv_r[1] <= wv_r[0];
      wv_r[0] <= t1 + t2;
    end
  end

endmodule

// ===== rtl/sha256_message_digest_core.sv =====
// sha256_message_digest_core: SHA-256 hasher, top level and sequencer.
// Depends on s256md_pkg, s256md_sched and s256md_round.
//
// Message bytes arrive one per input transfer and are taken at one per
// cycle while a block fills. The 64th byte of a block stalls the input
// while the block is compressed: 64 rounds through the single shared round
// unit, then a fold of the working variables into the hash. A transfer with
// last_byte set then pads the message one byte per cycle outside the
// compressions (the 0x80 marker, zero fill up to byte 56, and the eight
// length bytes), which runs one or two compressions, and finally hands out
// eight digest word transfers, word 0 first. A long message is limited by
// the one-round-per-cycle compression loop, during which no bytes are
// taken. The next message may start as soon as the last digest word is in
// the output register, while it still waits to be taken.
module sha256_message_digest_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  localparam logic [2:0] ST_IDLE = 3'd0;  // taking message bytes
  localparam logic [2:0] ST_MARK = 3'd1;  // shift in the 0x80 marker
  localparam logic [2:0] ST_ZERO = 3'd2;  // zero fill up to the length field
  localparam logic [2:0] ST_LEN  = 3'd3;  // eight big-endian length bytes
  localparam logic [2:0] ST_RND  = 3'd4;  // 64 compression rounds
  localparam logic [2:0] ST_FOLD = 3'd5;  // hash += working vars
  localparam logic [2:0] ST_EMIT = 3'd6;  // hand out the digest words

  logic [2:0]  state_r, state_nxt;
  logic [2:0]  ret_r, ret_nxt;       // where to go after a compression
  logic [5:0]  fill_r, fill_nxt;     // bytes held in the block
  logic [63:0] bits_r, bits_nxt;     // message length in bits
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  len_r, len_nxt;       // length byte being shifted
  logic [2:0]  widx_r, widx_nxt;     // digest word being loaded

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_word_r, out_word_nxt;
  logic [2:0]  out_idx_r, out_idx_nxt;
  logic        out_last_r, out_last_nxt;

  logic        in_xfer;
  logic        out_load;

  s256md_pkg::sched_ctl_t sch_ctl;
  s256md_pkg::rnd_ctl_t   rnd_ctl;
  s256md_pkg::word_t      w_cur;
  s256md_pkg::word_t      hash [8];

  s256md_sched u_sched (
    .clk   (clk),
    .ctl   (sch_ctl),
    .w_cur (w_cur)
  );

  s256md_round u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (rnd_ctl),
    .k_idx (rnd_r),
    .w_t   (w_cur),
    .hash  (hash)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  // Output register may be refilled when empty or when its word is taken
  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    fill_nxt      = fill_r;
    bits_nxt      = bits_r;
    rnd_nxt       = rnd_r;
    len_nxt       = len_r;
    widx_nxt      = widx_r;
    sch_ctl       = '0;
    rnd_ctl       = '0;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_byte_present) begin
            sch_ctl.shift_byte = 1'b1;
            sch_ctl.data       = in_data_byte;
            bits_nxt           = bits_r + 64'd8;
            fill_nxt           = fill_r + 6'd1;
            if (fill_r == 6'd63) begin
              // block full: compress, then pad if this ends the message
              rnd_ctl.load = 1'b1;
              state_nxt    = ST_RND;
              ret_nxt      = in_last_byte ? ST_MARK : ST_IDLE;
            end else if (in_last_byte) begin
              state_nxt = ST_MARK;
            end
          end else if (in_last_byte) begin
            state_nxt = ST_MARK;
          end
        end
      end
      ST_MARK: begin
        sch_ctl.shift_byte = 1'b1;
        sch_ctl.data       = s256md_pkg::PAD_MARKER;
        fill_nxt           = fill_r + 6'd1;
        if (fill_r == 6'd63) begin
          rnd_ctl.load = 1'b1;
          state_nxt    = ST_RND;
          ret_nxt      = ST_ZERO;
        end else begin
          state_nxt = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (fill_r == s256md_pkg::LEN_POS) begin
          state_nxt = ST_LEN;
        end else begin
          sch_ctl.shift_byte = 1'b1;
          sch_ctl.data       = 8'h00;
          fill_nxt           = fill_r + 6'd1;
          if (fill_r == 6'd63) begin
            // marker spilled past byte 56: finish this block first
            rnd_ctl.load = 1'b1;
            state_nxt    = ST_RND;
            ret_nxt      = ST_ZERO;
          end
        end
      end
      ST_LEN: begin
        sch_ctl.shift_byte = 1'b1;
        sch_ctl.data       = bits_r[{~len_r, 3'b000} +: 8];
        fill_nxt           = fill_r + 6'd1;
        len_nxt            = len_r + 3'd1;
        if (len_r == 3'd7) begin
          rnd_ctl.load = 1'b1;
          state_nxt    = ST_RND;
          ret_nxt      = ST_EMIT;
        end
      end
      ST_RND: begin
        rnd_ctl.step       = 1'b1;
        sch_ctl.shift_word = 1'b1;
        rnd_nxt            = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        rnd_ctl.fold = 1'b1;
        state_nxt    = ret_r;
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = hash[widx_r];
          out_idx_nxt   = widx_r;
          out_last_nxt  = (widx_r == 3'd7);
          widx_nxt      = widx_r + 3'd1;
          if (widx_r == 3'd7) begin
            rnd_ctl.restart = 1'b1;
            bits_nxt        = '0;
            fill_nxt        = '0;
            state_nxt       = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      fill_r      <= '0;
      bits_r      <= '0;
      rnd_r       <= '0;
      len_r       <= '0;
      widx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      fill_r      <= fill_nxt;
      bits_r      <= bits_nxt;
      rnd_r       <= rnd_nxt;
      len_r       <= len_nxt;
      widx_r      <= widx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = out_idx_r;
  assign out_last_word   = out_last_r;

`ifndef ASSERT_OFF
  // Compression only ever runs on a completely filled block
  a_rnd_full_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RND) |-> (fill_r == 6'd0))
    else $error("compression started on a partial block");

  // The fold follows exactly 64 rounds
  a_fold_after_64: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FOLD) |-> (rnd_r == 6'd0))
    else $error("round counter not wrapped at fold");

  // Digest words follow one another without a gap, in order
  a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_word) |=>
      (out_valid && (out_word_index == $past(out_word_index) + 3'd1)))
    else $error("digest words out of order");

  // A new message is taken only after the length count has been cleared
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_word && $rose(out_valid) == 1'b0 && state_r == ST_IDLE
      && $past(state_r) == ST_EMIT) |-> (bits_r == 64'd0))
    else $error("length not cleared after digest");
`endif

endmodule

// ===== tb/sha256_digest_check_pkg.sv =====
`timescale 1ns / 1ps
// sha256_digest_check_pkg: SHA-256 digest predictor and result scoreboard.
// Standalone; used by sha256_message_digest_core_tb.
package sha256_digest_check_pkg;

  typedef struct {
    bit [31:0] word;
    bit [2:0]  index;
    bit        last;
  } digest_beat_t;

  localparam bit [31:0] IV_WORDS [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam bit [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam bit [7:0] END_MARKER    = 8'h80;
  localparam int       LENGTH_OFFSET = 56;
  localparam int       BLOCK_BYTES   = 64;
  localparam int       MAX_REPORTS   = 40;

  class digest_scoreboard;
    bit [31:0]    chain [8];
    bit [7:0]     block_bytes [BLOCK_BYTES];
    int           fill;
    bit [63:0]    bit_count;
    digest_beat_t awaited [$];
    int           mismatches;
    int           words_checked;
    int           digests_expected;

    function new();
      restart();
      mismatches       = 0;
      words_checked    = 0;
      digests_expected = 0;
    endfunction

    function void restart();
      chain     = IV_WORDS;
      fill      = 0;
      bit_count = '0;
    endfunction

    static function bit [31:0] ror(bit [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      bit [31:0] w [64];
      bit [31:0] v [8];
      bit [31:0] s0, s1, t1, t2;
      for (int i = 0; i < 16; i++)
        w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
      for (int i = 16; i < 64; i++) begin
        s0   = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
        s1   = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
        w[i] = s1 + w[i-7] + s0 + w[i-16];
      end
      v = chain;
      for (int i = 0; i < 64; i++) begin
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[i] + w[i];
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++)
        chain[i] += v[i];
    endfunction

    // One accepted input transfer; queues the eight digest words on an end.
    function void note_input(bit [7:0] data, bit present, bit last);
      int           pos;
      digest_beat_t beat;
      if (present) begin
        block_bytes[fill] = data;
        fill++;
        bit_count += 64'd8;
        if (fill == BLOCK_BYTES) begin
          compress();
          fill = 0;
        end
      end
      if (!last)
        return;
      pos = fill;
      block_bytes[pos] = END_MARKER;
      pos++;
      if (pos > LENGTH_OFFSET) begin
        while (pos < BLOCK_BYTES) begin
          block_bytes[pos] = 8'h00;
          pos++;
        end
        compress();
        pos = 0;
      end
      while (pos < LENGTH_OFFSET) begin
        block_bytes[pos] = 8'h00;
        pos++;
      end
      for (int i = 0; i < 8; i++)
        block_bytes[LENGTH_OFFSET + i] = bit_count[63 - 8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
        beat.word  = chain[i];
        beat.index = 3'(i);
        beat.last  = (i == 7);
        awaited.push_back(beat);
      end
      digests_expected++;
      restart();
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task check_result(bit [31:0] word, bit [2:0] index, bit last);
      digest_beat_t want;
      if (awaited.size() == 0) begin
        report($sformatf("digest word %08h (index %0d) with nothing awaited", word, index));
        return;
      end
      want = awaited.pop_front();
      words_checked++;
      if (word !== want.word)
        report($sformatf("digest_word %08h, predicted %08h", word, want.word));
      if (index !== want.index)
        report($sformatf("word_index %0d, predicted %0d", index, want.index));
      if (last !== want.last)
        report($sformatf("last_word %0b, predicted %0b", last, want.last));
    endtask

    function int pending();
      return awaited.size();
    endfunction
  endclass

endpackage

// ===== tb/sha256_message_digest_core_tb.sv =====
`timescale 1ns / 1ps
// sha256_message_digest_core_tb: self-checking testbench of the SHA-256 core.
// Depends on sha256_digest_check_pkg and the RTL of sha256_message_digest_core.
module sha256_message_digest_core_tb;

  localparam int MESSAGE_ITEMS  = 470;   // byte / end transfers, no-ops excluded
  localparam int PHASE_ONE_END  = 160;
  localparam int PHASE_TWO_END  = 320;
  localparam int HOLD_CYCLES    = 1500;  // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 8000;  // well above hold plus two compressions
  localparam int DRAIN_CYCLES   = 300;   // > padding plus two compressions

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte    = 8'h00;
  logic        in_byte_present = 1'b0;
  logic        in_last_byte    = 1'b0;
  logic        out_valid;
  logic        out_stall       = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  sha256_digest_check_pkg::digest_scoreboard board;

  // Idle rates in percent; sender rate is private to the stimulus process,
  // receiver rate is handed over with a nonblocking write.
  int send_idle_pct = 17;
  int recv_idle_pct = 60;

  // Long hold-off of the receiver, requested once by the stimulus.
  logic hold_request = 1'b0;
  logic hold_done    = 1'b0;
  int   hold_left    = 0;

  int message_items = 0;  // transfers carrying a byte and/or an end
  int noop_items    = 0;  // transfers with neither, ignored by the core
  int bare_ends     = 0;  // ends without a byte
  int stuck_cycles  = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sha256_message_digest_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_byte_present(in_byte_present),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digest_word(out_digest_word),
    .out_word_index (out_word_index),
    .out_last_word  (out_last_word)
  );

  // Result side: random stall, plus one long hold-off so that the digest
  // output backs up, the core stops taking bytes and in_stall rises.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Result monitor. Reading right after the edge sees the values that the
  // core saw at that edge, so a transfer is exactly valid high, stall low.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_digest_word, out_word_index, out_last_word);
  end

  // Watchdog: cycles since the last transfer on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d digest words outstanding",
               stuck_cycles, board.pending());
      $display("[sha256_message_digest_core] ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Idle rates follow the run: sender light / receiver heavy, then the
  // reverse, then full rate with the long hold-off at its start.
  task automatic set_phase();
    if (message_items >= PHASE_TWO_END) begin
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      hold_request  <= 1'b1;
    end else if (message_items >= PHASE_ONE_END) begin
      send_idle_pct = 60;
      recv_idle_pct <= 17;
    end
  endtask

  // Offer one input transfer and wait until it is taken. Called at a
  // rising edge; every drive is a single nonblocking write in that step.
  task automatic send_item(input logic [7:0] data, input logic present, input logic last);
    set_phase();
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data_byte    <= data;
    in_byte_present <= present;
    in_last_byte    <= last;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    board.note_input(data, present, last);
    if (present || last)
      message_items++;
    else
      noop_items++;
    if (last && !present)
      bare_ends++;
  endtask

  // A message of random bytes; it ends on its final byte or on a separate
  // end without a byte. The odd no-op transfer is mixed in.
  task automatic send_message(input int len, input bit end_on_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0)
        send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
    end
    if (len == 0 || !end_on_byte)
      send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // Lengths either side of the padding and block boundaries, some long
  // messages, and mostly short ones.
  function automatic int pick_length();
    int edge_lengths [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 3)
      return edge_lengths[$urandom_range(0, 9)];
    else if (pick == 3)
      return $urandom_range(100, 200);
    return $urandom_range(0, 40);
  endfunction

  initial begin
    int msg_len;
    board = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part.
    send_item(8'h00, 1'b0, 1'b0);  // no byte, no end: ignored
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);  // empty message; data must be ignored
    send_item(8'h61, 1'b1, 1'b0);  // "abc", end on the final byte
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);  // one zero byte, then an end on its own
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);  // single byte and end together
    send_item(8'h00, 1'b0, 1'b1);  // empty again, straight after a digest
    send_item(8'h00, 1'b0, 1'b0);

    // Random messages until the byte budget is spent; the final message
    // is clipped to what is left of the budget.
    while (message_items < MESSAGE_ITEMS) begin
      msg_len = pick_length();
      if (msg_len > MESSAGE_ITEMS - message_items)
        msg_len = MESSAGE_ITEMS - message_items;
      send_message(msg_len, 1'($urandom));
    end
    in_valid <= 1'b0;

    while (board.pending() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d byte/end transfers (%0d bare ends), %0d no-op transfers",
             message_items, bare_ends, noop_items);
    $display("run: %0d digests, %0d digest words compared, one %0d-cycle output hold-off",
             board.digests_expected, board.words_checked, HOLD_CYCLES);
    if (board.mismatches == 0) begin
      $display("[sha256_message_digest_core] OK");
    end else begin
      $display("[sha256_message_digest_core] ERROR");
    end
    $finish;
  end

endmodule
